// ===== rtl/kdst_pkg.sv =====
package kdst_pkg;

   localparam int HASH_W = 32;
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

   // remainder reduction: hash bits folded in per cycle, and reduction steps per hash
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = HASH_W / MOD_BITS;

   localparam logic CMD_CHECK = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_KEY_ZERO = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic REG_KEY_LIMIT   = 1'b0;
   localparam logic REG_STATE_LIMIT = 1'b1;

   localparam logic [3:0] LIMIT_RESET = 4'd8;

endpackage

// ===== rtl/kdst_ram.sv =====
module kdst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/keyed_dirty_state_table.sv =====
// Direct-mapped change-detection table. A check word hashes its key with 32-bit
// FNV-1a, picks slot hash mod ENTRIES, and reports whether the key is new or its
// state changed, storing the new state. One word is in flight at a time: a check
// passes one key byte per cycle through the hash multiplier, then the 4-bit
// remainder reduction, one slot read, one compare/write-back on the slot RAM and
// the hand-over of the result to the output register, which waits while a held
// response is not yet taken. Rejected checks go straight to the response. A clear
// word sweeps the slot RAM one entry per cycle and then answers; the same sweep
// runs after reset before the first word is taken. Configuration writes are taken
// throughout.
module keyed_dirty_state_table
   import kdst_pkg::*;
#(
   parameter int ENTRIES         = 256,
   parameter int KEY_BYTES_MAX   = 8,
   parameter int STATE_BYTES_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_len,
   input  logic [63:0] req_state_bytes,
   input  logic [3:0]  req_state_len,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_changed,
   output logic        rsp_evicted,
   output logic [7:0]  rsp_slot_index,

   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int RW  = $clog2(ENTRIES);
   localparam int EW  = RW + 1;
   localparam int KIW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
   localparam int MCW = $clog2(MOD_STEPS);

   typedef struct packed {
      logic                                valid;
      logic [3:0]                          key_len;
      logic [3:0]                          state_len;
      logic [KEY_BYTES_MAX-1:0][7:0]       key;
      logic [STATE_BYTES_MAX-1:0][7:0]     state;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CMP, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic [RW-1:0] clr_addr_ff, clr_addr_in;
   logic [KIW-1:0] hcnt_ff, hcnt_in;
   logic [MCW-1:0] mcnt_ff, mcnt_in;
   logic [3:0] key_limit_ff, key_limit_in;
   logic [3:0] state_limit_ff, state_limit_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [KEY_BYTES_MAX-1:0][7:0]   key_ff, key_in;
   logic [STATE_BYTES_MAX-1:0][7:0] st_ff, st_in;
   logic [3:0]        klen_ff, klen_in;
   logic [3:0]        slen_ff, slen_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [RW-1:0]     r_ff, r_in;
   logic [1:0] res_status_ff, res_status_in;
   logic       res_changed_ff, res_changed_in;
   logic       res_evicted_ff, res_evicted_in;
   logic [7:0] res_slot_ff, res_slot_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_changed_ff, rsp_changed_in;
   logic       rsp_evicted_ff, rsp_evicted_in;
   logic [7:0] rsp_slot_ff, rsp_slot_in;

   logic              ram_wr_en;
   logic [RW-1:0]     ram_wr_addr;
   slot_type          ram_wr_slot;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_data;
   slot_type          rd_slot;

   logic [HASH_W-1:0] hash_mul;
   logic [RW-1:0]     mod_r;
   logic [EW-1:0]     mod_t;
   logic              too_long;
   logic              hit;
   logic              same_state;

   kdst_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_slot),
      .rd_en   (ram_rd_en),
      .rd_addr (r_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_slot = ram_rd_data;

   assign hash_mul = (h_ff ^ HASH_W'(key_ff[hcnt_ff])) * FNV_PRIME;

   always_comb begin
      mod_r = r_ff;
      mod_t = '0;
      for (int j = 0; j < MOD_BITS; j++) begin
         mod_t = {mod_r, h_ff[HASH_W-1-j]};
         if (mod_t >= EW'(ENTRIES)) begin
            mod_t = mod_t - EW'(ENTRIES);
         end
         mod_r = mod_t[RW-1:0];
      end
   end

   assign too_long = (req_key_len > key_limit_ff) || (req_key_len > 4'(KEY_BYTES_MAX)) ||
                     (req_state_len > state_limit_ff) ||
                     (req_state_len > 4'(STATE_BYTES_MAX));

   assign hit = rd_slot.valid && (rd_slot.key_len == klen_ff) && (rd_slot.key == key_ff);
   assign same_state = (rd_slot.state_len == slen_ff) && (rd_slot.state == st_ff);

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_changed    = rsp_changed_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_slot_index = rsp_slot_ff;

   always_comb begin
      state_in       = state_ff;
      pend_in        = pend_ff;
      clr_addr_in    = clr_addr_ff;
      hcnt_in        = hcnt_ff;
      mcnt_in        = mcnt_ff;
      key_limit_in   = key_limit_ff;
      state_limit_in = state_limit_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      key_in         = key_ff;
      st_in          = st_ff;
      klen_in        = klen_ff;
      slen_in        = slen_ff;
      h_in           = h_ff;
      r_in           = r_ff;
      res_status_in  = res_status_ff;
      res_changed_in = res_changed_ff;
      res_evicted_in = res_evicted_ff;
      res_slot_in    = res_slot_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_slot_in    = rsp_slot_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = r_ff;
      ram_wr_slot    = '0;
      ram_rd_en      = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_KEY_LIMIT:   key_limit_in   = csr_wdata;
            REG_STATE_LIMIT: state_limit_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == RW'(ENTRIES - 1)) begin
               state_in = pend_ff ? S_RESP : S_IDLE;
               pend_in  = 1'b0;
            end
         end
         S_IDLE: begin
            for (int i = 0; i < KEY_BYTES_MAX; i++) begin
               key_in[i] = (4'(i) < req_key_len) ? req_key_bytes[8*i +: 8] : 8'h00;
            end
            for (int i = 0; i < STATE_BYTES_MAX; i++) begin
               st_in[i] = (4'(i) < req_state_len) ? req_state_bytes[8*i +: 8] : 8'h00;
            end
            klen_in        = req_key_len;
            slen_in        = req_state_len;
            h_in           = FNV_BASIS;
            hcnt_in        = '0;
            res_status_in  = STATUS_OK;
            res_changed_in = 1'b0;
            res_evicted_in = 1'b0;
            res_slot_in    = 8'h00;
            if (req_valid) begin
               priority if (req_cmd == CMD_CLEAR) begin
                  pend_in     = 1'b1;
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else if (req_key_len == 4'd0) begin
                  res_status_in = STATUS_KEY_ZERO;
                  state_in      = S_RESP;
               end else if (too_long) begin
                  res_status_in = STATUS_TOO_LONG;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            h_in    = hash_mul;
            hcnt_in = hcnt_ff + 1'b1;
            if ((4'(hcnt_ff) + 4'd1) == klen_ff) begin
               r_in     = '0;
               mcnt_in  = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            r_in    = mod_r;
            h_in    = h_ff << MOD_BITS;
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == MCW'(MOD_STEPS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            res_slot_in    = 8'(r_ff);
            res_changed_in = !(hit && same_state);
            res_evicted_in = !hit && rd_slot.valid;
            ram_wr_en      = !(hit && same_state);
            ram_wr_slot.valid     = 1'b1;
            ram_wr_slot.key_len   = klen_ff;
            ram_wr_slot.state_len = slen_ff;
            ram_wr_slot.key       = key_ff;
            ram_wr_slot.state     = st_ff;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_changed_in = res_changed_ff;
               rsp_evicted_in = res_evicted_ff;
               rsp_slot_in    = res_slot_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         pend_ff        <= 1'b0;
         clr_addr_ff    <= '0;
         hcnt_ff        <= '0;
         mcnt_ff        <= '0;
         key_limit_ff   <= LIMIT_RESET;
         state_limit_ff <= LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_ff        <= pend_in;
         clr_addr_ff    <= clr_addr_in;
         hcnt_ff        <= hcnt_in;
         mcnt_ff        <= mcnt_in;
         key_limit_ff   <= key_limit_in;
         state_limit_ff <= state_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff         <= key_in;
      st_ff          <= st_in;
      klen_ff        <= klen_in;
      slen_ff        <= slen_in;
      h_ff           <= h_in;
      r_ff           <= r_in;
      res_status_ff  <= res_status_in;
      res_changed_ff <= res_changed_in;
      res_evicted_ff <= res_evicted_in;
      res_slot_ff    <= res_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

endmodule

// ===== test/testbench.sv =====
module testbench;
   import kdst_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam logic [3:0] BYTES_CAP = 4'd8;
   localparam int POOL_SIZE = 40;
   localparam int CROWDED_KEYS = 16;

   typedef struct packed {
      logic [1:0] status;
      logic       changed;
      logic       evicted;
      logic [7:0] slot_index;
   } verdict_type;

   typedef enum int {RX_OPEN, RX_THIRD, RX_COIN, RX_CHOKE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_CHECK;
   logic [63:0] req_key_bytes = '0;
   logic [3:0]  req_key_len = '0;
   logic [63:0] req_state_bytes = '0;
   logic [3:0]  req_state_len = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_changed;
   logic        rsp_evicted;
   logic [7:0]  rsp_slot_index;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = REG_KEY_LIMIT;
   logic [3:0]  csr_wdata = '0;

   logic [3:0]  key_limit_q = LIMIT_RESET;
   logic [3:0]  state_limit_q = LIMIT_RESET;
   logic [TABLE_DEPTH-1:0] slot_valid = '0;
   logic [31:0] slot_hash [TABLE_DEPTH];
   logic [3:0]  slot_key_len [TABLE_DEPTH];
   logic [3:0]  slot_state_len [TABLE_DEPTH];
   logic [63:0] slot_key [TABLE_DEPTH];
   logic [63:0] slot_state [TABLE_DEPTH];

   logic [63:0] pool_key [POOL_SIZE];
   logic [3:0]  pool_klen [POOL_SIZE];
   logic [63:0] pool_state [POOL_SIZE];
   logic [3:0]  pool_slen [POOL_SIZE];

   verdict_type expected_verdicts [$];
   int          mismatch_count = 0;
   int          word_count = 0;
   int          burst_left = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_tick = 0;

   keyed_dirty_state_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_key_bytes   (req_key_bytes),
      .req_key_len     (req_key_len),
      .req_state_bytes (req_state_bytes),
      .req_state_len   (req_state_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_changed     (rsp_changed),
      .rsp_evicted     (rsp_evicted),
      .rsp_slot_index  (rsp_slot_index),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] byte_mask_of(logic [3:0] len);
      if (len >= 4'd8) begin
         return '1;
      end
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   function automatic logic [31:0] fnv1a_hash(logic [63:0] key, logic [3:0] len);
      logic [31:0] h;
      h = FNV_BASIS;
      for (int i = 0; i < 8; i++) begin
         if (i < len) begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * FNV_PRIME;
         end
      end
      return h;
   endfunction

   function automatic verdict_type predict_verdict(logic cmd, logic [63:0] key_raw,
                                                   logic [3:0] klen, logic [63:0] st_raw,
                                                   logic [3:0] slen);
      verdict_type v;
      logic [3:0]  klim;
      logic [3:0]  slim;
      logic [63:0] key;
      logic [63:0] st;
      logic [31:0] h;
      int          idx;
      logic        hit;
      v = '{status: STATUS_OK, changed: 1'b0, evicted: 1'b0, slot_index: 8'd0};
      if (cmd == CMD_CLEAR) begin
         slot_valid = '0;
         return v;
      end
      klim = (key_limit_q > BYTES_CAP) ? BYTES_CAP : key_limit_q;
      slim = (state_limit_q > BYTES_CAP) ? BYTES_CAP : state_limit_q;
      if (klen == 4'd0) begin
         v.status = STATUS_KEY_ZERO;
         return v;
      end
      if (klen > klim || slen > slim) begin
         v.status = STATUS_TOO_LONG;
         return v;
      end
      key = key_raw & byte_mask_of(klen);
      st = st_raw & byte_mask_of(slen);
      h = fnv1a_hash(key, klen);
      idx = int'(h % TABLE_DEPTH);
      v.slot_index = idx[7:0];
      hit = slot_valid[idx] && slot_hash[idx] == h && slot_key_len[idx] == klen &&
            slot_key[idx] == key;
      if (hit && slot_state_len[idx] == slen && slot_state[idx] == st) begin
         return v;
      end
      v.changed = 1'b1;
      v.evicted = !hit && slot_valid[idx];
      slot_valid[idx] = 1'b1;
      slot_hash[idx] = h;
      slot_key_len[idx] = klen;
      slot_state_len[idx] = slen;
      slot_key[idx] = key;
      slot_state[idx] = st;
      return v;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("mismatch on response %0d: %s got %0h want %0h", word_count, field, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(logic cmd, logic [63:0] kb, logic [3:0] kl,
                            logic [63:0] sb, logic [3:0] sl);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_cmd = cmd;
      req_key_bytes = kb;
      req_key_len = kl;
      req_state_bytes = sb;
      req_state_len = sl;
      req_valid = 1'b1;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      expected_verdicts.push_back(predict_verdict(cmd, kb, kl, sb, sl));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (expected_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic set_limits(logic [3:0] key_lim, logic [3:0] state_lim);
      wait_drained();
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = REG_KEY_LIMIT;
      csr_wdata = key_lim;
      @(negedge clock);
      csr_index = REG_STATE_LIMIT;
      csr_wdata = state_lim;
      @(negedge clock);
      csr_wr_en = 1'b0;
      key_limit_q = key_lim;
      state_limit_q = state_lim;
   endtask

   task automatic test_lookup_basics();
      send_word(CMD_CHECK, rand64(), 4'd0, rand64(), 4'd8);
      send_word(CMD_CHECK, 64'd0, 4'd1, 64'd0, 4'd0);
      send_word(CMD_CHECK, 64'd0, 4'd1, 64'd0, 4'd0);
      send_word(CMD_CHECK, '1, 4'd8, '1, 4'd8);
      send_word(CMD_CHECK, '1, 4'd8, '1, 4'd8);
      send_word(CMD_CHECK, '1, 4'd8, '1, 4'd7);
      // junk above the lengths must not matter
      send_word(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '1, 4'd0);
      send_word(CMD_CHECK, 64'd0, 4'd2, 64'h0123_4567_89AB_CDEF, 4'd5);
      send_word(CMD_CLEAR, rand64(), 4'd3, rand64(), 4'd3);
      send_word(CMD_CHECK, 64'd0, 4'd1, 64'd0, 4'd0);
   endtask

   task automatic test_limit_registers();
      set_limits(4'd0, 4'd8);
      send_word(CMD_CHECK, rand64(), 4'd1, rand64(), 4'd0);
      send_word(CMD_CHECK, rand64(), 4'd0, rand64(), 4'd0);
      set_limits(4'd15, 4'd0);
      send_word(CMD_CHECK, '1, 4'd8, rand64(), 4'd0);
      send_word(CMD_CHECK, '1, 4'd8, rand64(), 4'd1);
      set_limits(4'd3, 4'd15);
      send_word(CMD_CHECK, rand64(), 4'd4, rand64(), 4'd2);
      send_word(CMD_CHECK, rand64(), 4'd3, rand64(), 4'd8);
      set_limits(4'd1, 4'd1);
      send_word(CMD_CHECK, rand64(), 4'd2, rand64(), 4'd1);
      send_word(CMD_CHECK, rand64(), 4'd1, rand64(), 4'd1);
      set_limits(LIMIT_RESET, LIMIT_RESET);
   endtask

   task automatic test_slot_eviction();
      logic [63:0] key_a;
      logic [63:0] key_b;
      logic [63:0] st_a;
      logic [31:0] slot_a;
      key_a = rand64() & byte_mask_of(4'd4);
      slot_a = fnv1a_hash(key_a, 4'd4) % TABLE_DEPTH;
      do key_b = rand64() & byte_mask_of(4'd4);
      while (key_b == key_a || fnv1a_hash(key_b, 4'd4) % TABLE_DEPTH != slot_a);
      st_a = rand64();
      send_word(CMD_CHECK, key_a, 4'd4, st_a, 4'd3);
      send_word(CMD_CHECK, key_b, 4'd4, rand64(), 4'd5);
      send_word(CMD_CHECK, key_a, 4'd4, st_a, 4'd3);
      send_word(CMD_CHECK, key_a, 4'd4, st_a, 4'd3);
   endtask

   task automatic run_phase(logic [3:0] key_lim, logic [3:0] state_lim, int count);
      int          r;
      int          p;
      int          q;
      logic        cmd;
      logic [63:0] kb;
      logic [63:0] sb;
      logic [3:0]  kl;
      logic [3:0]  sl;
      logic [3:0]  klim;
      logic [3:0]  slim;
      set_limits(key_lim, state_lim);
      klim = (key_lim > BYTES_CAP) ? BYTES_CAP : key_lim;
      slim = (state_lim > BYTES_CAP) ? BYTES_CAP : state_lim;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         cmd = CMD_CHECK;
         kb = rand64();
         sb = rand64();
         kl = 4'($urandom_range(1, 8));
         sl = 4'($urandom_range(0, 8));
         if (r < 3) begin
            cmd = CMD_CLEAR;
            kl = 4'($urandom_range(0, 8));
         end else if (r < 7) begin
            kl = 4'd0;
         end else if (r >= 14 && klim != 4'd0) begin
            kl = 4'($urandom_range(1, klim));
            sl = 4'($urandom_range(0, slim));
            p = -1;
            if ($urandom_range(0, 4) != 0) begin
               for (int t = 0; t < 4 && p < 0; t++) begin
                  q = $urandom_range(0, POOL_SIZE - 1);
                  if (pool_klen[q] <= klim) begin
                     p = q;
                  end
               end
            end
            if (p >= 0) begin
               kl = pool_klen[p];
               kb = pool_key[p] | (($urandom_range(0, 1) == 0 ? rand64() : 64'd0) &
                                   ~byte_mask_of(kl));
               if ($urandom_range(0, 1) == 0 && pool_slen[p] <= slim) begin
                  sl = pool_slen[p];
                  sb = pool_state[p] | (rand64() & ~byte_mask_of(sl));
               end else begin
                  pool_slen[p] = sl;
                  pool_state[p] = sb & byte_mask_of(sl);
               end
            end
         end
         send_word(cmd, kb, kl, sb, sl);
      end
   endtask

   task automatic test_random_traffic();
      // crowd the first keys into a few slots so evictions are frequent
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_klen[i] = 4'($urandom_range(1, 8));
         do pool_key[i] = rand64() & byte_mask_of(pool_klen[i]);
         while (i < CROWDED_KEYS && fnv1a_hash(pool_key[i], pool_klen[i]) % TABLE_DEPTH >= 4);
         pool_slen[i] = 4'($urandom_range(0, 8));
         pool_state[i] = rand64() & byte_mask_of(pool_slen[i]);
      end
      run_phase(4'd8, 4'd8, 300);
      run_phase(4'd15, 4'd15, 250);
      run_phase(4'($urandom_range(1, 8)), 4'($urandom_range(0, 8)), 250);
      run_phase(4'd8, 4'd0, 150);
      run_phase(4'd0, 4'($urandom_range(0, 15)), 30);
      run_phase(4'($urandom_range(9, 15)), 4'($urandom_range(1, 7)), 200);
      run_phase(LIMIT_RESET, LIMIT_RESET, 270);
   endtask

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN: rsp_ready = 1'b1;
         RX_THIRD: rsp_ready = (rx_tick % 3 == 0);
         RX_COIN: rsp_ready = 1'($urandom_range(0, 1));
         default: rsp_ready = (rx_tick % 10 >= 8);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         word_count++;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected response", rsp_status, 0);
         end else begin
            verdict_type want;
            want = expected_verdicts.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_changed !== want.changed)
               report_mismatch("changed", rsp_changed, want.changed);
            if (rsp_evicted !== want.evicted)
               report_mismatch("evicted", rsp_evicted, want.evicted);
            if (rsp_slot_index !== want.slot_index)
               report_mismatch("slot_index", rsp_slot_index, want.slot_index);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_lookup_basics();
      test_limit_registers();
      test_slot_eviction();
      test_random_traffic();
      wait_drained();
      // cover the sweep that follows a clear
      repeat (300) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("keyed_dirty_state_table verification clean");
      end else begin
         $display("keyed_dirty_state_table verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("keyed_dirty_state_table verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/kdst_pkg.sv
rtl/kdst_ram.sv
rtl/keyed_dirty_state_table.sv
test/testbench.sv
